// ===== design/swtbs_pkg.sv =====
// Shared constants, codes and types of the sorted word table search block.
package swtbs_pkg;

  localparam int TABLE_DEPTH = 16384;
  localparam int MAX_LETTERS = 8;
  localparam int WORD_W      = 64;
  localparam int INDEX_W     = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

  localparam logic [WORD_W-1:0] LETTER_MASK =
    (MAX_LETTERS >= 8) ? {WORD_W{1'b1}} :
    ~((WORD_W'(1) << (8 * (8 - MAX_LETTERS))) - WORD_W'(1));

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [COUNT_W-1:0] count_t;

endpackage

// ===== design/swtbs_if.sv =====
// Request and response channel interfaces of the sorted word table search block.
interface swtbs_req_if;
  logic                 valid;
  logic                 ready;
  logic                 action;
  swtbs_pkg::word_t     word;

  modport source (output valid, output action, output word, input ready);
  modport sink   (input valid, input action, input word, output ready);
endinterface

interface swtbs_rsp_if;
  logic                 valid;
  logic                 ready;
  logic                 found;
  swtbs_pkg::index_t    match_index;
  logic                 load_rejected;

  modport source (output valid, output found, output match_index, output load_rejected,
                  input ready);
  modport sink   (input valid, input found, input match_index, input load_rejected,
                  output ready);
endinterface

// ===== design/swtbs_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module swtbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/sorted_word_table_binary_search_top.sv =====
// Top level of the sorted word table with binary search lookup.
//
// Usage: the req channel carries one beat per item: action selects a load
// (append word at the next index) or a lookup (binary search for word).
// The rsp channel returns exactly one beat per item: found, match_index and
// load_rejected. Words are masked to the configured letter count first.
// A load goes from acceptance to the finish state, which writes the output
// register once it is free, and then returns to idle; a load into a
// full table is flagged and leaves the table unchanged.
// A lookup runs one probe per pass through the search and wait states, each
// one registered read of the word memory and one 64-bit compare; it ends on a
// hit, or on a miss when one more pass finds the range empty. A table of n
// words needs at most floor(log2(n)) + 1 probes.
// One item is in work at a time; req.ready is high only while the search
// engine is free. A finished result sits in the output register while the
// next item is accepted; if the receiver still stalls when that next result
// is ready, the engine holds it until rsp is free.
// Reset clears the word count and the output valid; the word memory has no
// clearing pass and is read only below the word count.
module sorted_word_table_binary_search_top (
  input logic clk,
  input logic rst,
  swtbs_req_if.sink   req,
  swtbs_rsp_if.source rsp
);

  localparam int CW = swtbs_pkg::COUNT_W;
  localparam int IW = swtbs_pkg::INDEX_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_FIN    = 2'd3;

  logic [1:0]          state;
  swtbs_pkg::count_t   count;
  swtbs_pkg::word_t    key;
  swtbs_pkg::count_t   lo;
  swtbs_pkg::count_t   hi_excl;
  swtbs_pkg::index_t   mid;
  logic                res_found;
  swtbs_pkg::index_t   res_index;
  logic                res_rejected;
  logic                out_valid;
  logic                out_found;
  swtbs_pkg::index_t   out_index;
  logic                out_rejected;

  logic                accept;
  logic                full;
  logic                load_we;
  logic                probe_re;
  logic [CW:0]         mid_sum;
  swtbs_pkg::index_t   mid_calc;
  swtbs_pkg::word_t    masked_word;
  swtbs_pkg::word_t    probe;
  logic                fin_fire;

  assign req.ready   = (state == ST_IDLE);
  assign accept      = req.valid && req.ready;
  assign full        = (count == CW'(swtbs_pkg::TABLE_DEPTH));
  assign masked_word = req.word & swtbs_pkg::LETTER_MASK;
  assign load_we     = accept && (req.action == swtbs_pkg::ACT_LOAD) && !full;
  assign mid_sum     = {1'b0, lo} + {1'b0, hi_excl} - (CW + 1)'(1);
  assign mid_calc    = mid_sum[IW:1];
  assign probe_re    = (state == ST_SEARCH) && (lo < hi_excl);
  assign fin_fire    = (state == ST_FIN) && (!out_valid || rsp.ready);

  swtbs_ram #(
    .WIDTH (swtbs_pkg::WORD_W),
    .DEPTH (swtbs_pkg::TABLE_DEPTH)
  ) u_word_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (count[IW-1:0]),
    .wdata (masked_word),
    .re    (probe_re),
    .raddr (mid_calc),
    .rdata (probe)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_found    <= 1'b0;
            res_index    <= '0;
            res_rejected <= 1'b0;
            if (req.action == swtbs_pkg::ACT_LOAD) begin
              if (full) begin
                res_rejected <= 1'b1;
              end else begin
                count <= count + CW'(1);
              end
              state <= ST_FIN;
            end else begin
              key     <= masked_word;
              lo      <= '0;
              hi_excl <= count;
              state   <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (probe_re) begin
            mid   <= mid_calc;
            state <= ST_WAIT;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_WAIT: begin
          if (key < probe) begin
            hi_excl <= {1'b0, mid};
            state   <= ST_SEARCH;
          end else if (key > probe) begin
            lo    <= {1'b0, mid} + CW'(1);
            state <= ST_SEARCH;
          end else begin
            res_found <= 1'b1;
            res_index <= mid;
            state     <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_fire) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_found    <= res_found;
      out_index    <= res_index;
      out_rejected <= res_rejected;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.found         = out_found;
  assign rsp.match_index   = out_index;
  assign rsp.load_rejected = out_rejected;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(swtbs_pkg::TABLE_DEPTH))
    else $error("word count beyond table depth");

  a_probe_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT) |-> ({1'b0, mid} < count))
    else $error("probe outside loaded words");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_found && out_rejected))
    else $error("result both found and rejected");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("engine idle after accepting a beat");
`endif

endmodule

// ===== tb/tb_sorted_word_table_binary_search_top.sv =====
// Self-checking testbench for the sorted word table block: loads and binary search lookups.
module tb_sorted_word_table_binary_search_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              found;
    swtbs_pkg::index_t match_index;
    logic              load_rejected;
  } result_t;

  typedef struct packed {
    logic             act;
    swtbs_pkg::word_t word;
    logic             typed;
    result_t          res;
  } stim_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  localparam result_t          RES_NONE  = '0;
  localparam result_t          RES_AT0   = '{found: 1'b1, match_index: '0,
                                             load_rejected: 1'b0};
  localparam swtbs_pkg::word_t ALL_ONES  = {swtbs_pkg::WORD_W{1'b1}};
  localparam swtbs_pkg::word_t LOAD_BASE = 64'h4500_0000_0000_0000;
  localparam swtbs_pkg::word_t W_APPLE   = 64'h4150_504C_4500_0000;
  localparam swtbs_pkg::word_t W_BANANA  = 64'h4241_4E41_4E41_0000;
  localparam swtbs_pkg::word_t W_CHERRY  = 64'h4348_4552_5259_0000;
  localparam swtbs_pkg::word_t W_D0G     = 64'h4400_4700_0000_0000;
  localparam swtbs_pkg::word_t W_D       = 64'h4400_0000_0000_0000;
  localparam swtbs_pkg::word_t W_ZZZ     = 64'h5A5A_5A5A_5A5A_5A5A;
  localparam int      RANDOM_ITEMS = 900;
  localparam int      FULL_ITEMS   = 40;
  localparam int      HOLD_AT      = 300;
  localparam int      HOLD_CYCLES  = 400;

  logic clk;
  logic rst;

  swtbs_req_if req_ch ();
  swtbs_rsp_if rsp_ch ();

  sorted_word_table_binary_search_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  swtbs_pkg::word_t shadow_words [swtbs_pkg::TABLE_DEPTH];
  int        shadow_count;
  int        next_rank;
  result_t   pending_results [$];
  stim_row_t dir_rows [18];
  int        errors;
  int        beats_sent;
  int        burst_left;
  int        n_loads, n_refused, n_lookups, n_hits;
  bit        hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timeout at %0t", $time);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic swtbs_pkg::word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic result_t search_or_append(input logic act, input swtbs_pkg::word_t raw);
    swtbs_pkg::word_t key;
    int               lo, hi, mid;
    result_t          r;
    key = raw & swtbs_pkg::LETTER_MASK;
    r   = '0;
    if (act == swtbs_pkg::ACT_LOAD) begin
      if (shadow_count < swtbs_pkg::TABLE_DEPTH) begin
        shadow_words[shadow_count] = key;
        shadow_count++;
      end else begin
        r.load_rejected = 1'b1;
      end
    end else begin
      lo = 0;
      hi = shadow_count - 1;
      while (lo <= hi && !r.found) begin
        mid = (lo + hi) / 2;
        if (key < shadow_words[mid]) begin
          hi = mid - 1;
        end else if (key > shadow_words[mid]) begin
          lo = mid + 1;
        end else begin
          r.found       = 1'b1;
          r.match_index = swtbs_pkg::index_t'(mid);
        end
      end
    end
    return r;
  endfunction

  function automatic swtbs_pkg::word_t pick_probe();
    int sel, idx;
    sel = $urandom_range(0, 99);
    if (shadow_count == 0 || sel < 15) return rand_word();
    idx = $urandom_range(0, shadow_count - 1);
    if (sel < 65) return shadow_words[idx];
    if (sel < 75) return shadow_words[idx] + 1;
    if (sel < 85) return shadow_words[idx] - 1;
    if (sel < 92) return shadow_words[0];
    return shadow_words[shadow_count - 1];
  endfunction

  function automatic swtbs_pkg::word_t next_load_word(input bit noisy);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8 && shadow_count > 0) return shadow_words[shadow_count - 1];
    if (noisy && sel < 14) return rand_word();
    next_rank++;
    return LOAD_BASE + (swtbs_pkg::word_t'(next_rank) << 40) +
           {24'b0, $urandom, 8'($urandom)};
  endfunction

  task automatic send_beat(input logic act, input swtbs_pkg::word_t w, input logic typed,
                           input result_t typed_res);
    result_t r;
    int      gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        req_ch.valid  <= 1'b0;
        req_ch.action <= 1'($urandom);
        req_ch.word   <= rand_word();
      end
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.word   <= w;
    do @(posedge clk); while (!req_ch.ready);
    r = search_or_append(act, w);
    pending_results.push_back(typed ? typed_res : r);
    beats_sent++;
    if (act == swtbs_pkg::ACT_LOAD) begin
      n_loads++;
      if (r.load_rejected) n_refused++;
    end else begin
      n_lookups++;
      if (r.found) n_hits++;
    end
  endtask

  // Receiver: shifting stall patterns, plus one long hold-off to back up the request side.
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       cyc;
    mode      = RX_OPEN;
    mode_left = 0;
    cyc       = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (!hold_done && beats_sent >= HOLD_AT) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          RX_OPEN:     rsp_ch.ready <= 1'b1;
          RX_COIN:     rsp_ch.ready <= 1'($urandom);
          RX_SPARSE:   rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default:     rsp_ch.ready <= ((cyc % 8) < 5);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending: found=%0b index=%0d rejected=%0b",
                 $time, rsp_ch.found, rsp_ch.match_index, rsp_ch.load_rejected);
      end else begin
        e = pending_results.pop_front();
        if (rsp_ch.found !== e.found) begin
          errors++;
          $display("%0t: found expected %0b actual %0b", $time, e.found, rsp_ch.found);
        end
        if (rsp_ch.match_index !== e.match_index) begin
          errors++;
          $display("%0t: match_index expected %0d actual %0d",
                   $time, e.match_index, rsp_ch.match_index);
        end
        if (rsp_ch.load_rejected !== e.load_rejected) begin
          errors++;
          $display("%0t: load_rejected expected %0b actual %0b",
                   $time, e.load_rejected, rsp_ch.load_rejected);
        end
      end
    end
  end

  initial begin
    logic             act;
    swtbs_pkg::word_t w;
    rst           = 1'b1;
    req_ch.valid  = 1'b0;
    req_ch.action = swtbs_pkg::ACT_LOAD;
    req_ch.word   = '0;
    shadow_count  = 0;
    next_rank     = 0;
    errors        = 0;
    beats_sent    = 0;
    burst_left    = 0;
    n_loads       = 0;
    n_refused     = 0;
    n_lookups     = 0;
    n_hits        = 0;
    hold_done     = 1'b0;

    dir_rows = '{
      '{swtbs_pkg::ACT_LOOKUP, '0,       1'b1, RES_NONE},
      '{swtbs_pkg::ACT_LOOKUP, ALL_ONES, 1'b1, RES_NONE},
      '{swtbs_pkg::ACT_LOAD,   '0,       1'b1, RES_NONE},
      '{swtbs_pkg::ACT_LOOKUP, '0,       1'b1, RES_AT0},
      '{swtbs_pkg::ACT_LOAD,   W_APPLE,  1'b1, RES_NONE},
      '{swtbs_pkg::ACT_LOAD,   W_BANANA, 1'b1, RES_NONE},
      '{swtbs_pkg::ACT_LOAD,   W_CHERRY, 1'b1, RES_NONE},
      '{swtbs_pkg::ACT_LOAD,   W_CHERRY, 1'b1, RES_NONE},
      '{swtbs_pkg::ACT_LOAD,   W_D0G,    1'b1, RES_NONE},
      '{swtbs_pkg::ACT_LOOKUP, W_APPLE,  1'b0, RES_NONE},
      '{swtbs_pkg::ACT_LOOKUP, W_BANANA, 1'b0, RES_NONE},
      '{swtbs_pkg::ACT_LOOKUP, W_CHERRY, 1'b0, RES_NONE},
      '{swtbs_pkg::ACT_LOOKUP, W_D0G,    1'b0, RES_NONE},
      '{swtbs_pkg::ACT_LOOKUP, W_D,      1'b1, RES_NONE},
      '{swtbs_pkg::ACT_LOOKUP, 64'h1,    1'b1, RES_NONE},
      '{swtbs_pkg::ACT_LOOKUP, W_ZZZ,    1'b1, RES_NONE},
      '{swtbs_pkg::ACT_LOOKUP, ALL_ONES, 1'b1, RES_NONE},
      '{swtbs_pkg::ACT_LOOKUP, '0,       1'b0, RES_NONE}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k])
      send_beat(dir_rows[k].act, dir_rows[k].word, dir_rows[k].typed, dir_rows[k].res);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      act = 1'($urandom);
      w   = (act == swtbs_pkg::ACT_LOAD) ? next_load_word(1'b1) : pick_probe();
      send_beat(act, w, 1'b0, RES_NONE);
    end

    // put the largest word at the end, then look it up
    send_beat(swtbs_pkg::ACT_LOAD, ALL_ONES, 1'b1, RES_NONE);
    send_beat(swtbs_pkg::ACT_LOOKUP, ALL_ONES, 1'b0, RES_NONE);

    for (int i = 0; i < FULL_ITEMS; i++) begin
      act = 1'($urandom);
      w   = (act == swtbs_pkg::ACT_LOAD) ? rand_word() : pick_probe();
      send_beat(act, w, 1'b0, RES_NONE);
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("ran %0d loads (%0d refused on a full table) and %0d lookups (%0d hits)",
             n_loads, n_refused, n_lookups, n_hits);
    $display("table reached %0d words; response side held off once for %0d cycles",
             shadow_count, HOLD_CYCLES);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
